// ===== rtl/core/bcc_pkg.sv =====
`timescale 1ns / 1ps

package bcc_pkg;

  // Configuration register widths and reset values.
  localparam int unsigned TickW       = 8;
  localparam int unsigned HoldW       = TickW + 1;
  localparam int unsigned CfgIdxW     = 2;
  localparam logic [TickW-1:0] LongPressReset   = 8'd200;
  localparam logic [TickW-1:0] DoubleWinReset   = 8'd10;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgLongPress = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgDoubleWin = 2'd1;

  typedef enum logic [1:0] {
    EvNone   = 2'd0,
    EvShort  = 2'd1,
    EvLong   = 2'd2,
    EvDouble = 2'd3
  } click_event_e;

  typedef enum logic [1:0] {
    ClsDown  = 2'd0,
    ClsUp    = 2'd1,
    ClsShort = 2'd2,
    ClsLong  = 2'd3
  } press_class_e;

  typedef enum logic [4:0] {
    StIdle    = 5'b00001,
    StHold    = 5'b00010,
    StSettle  = 5'b00100,
    StRelease = 5'b01000,
    StSecond  = 5'b10000
  } gesture_step_e;

  typedef struct packed {
    logic key_pressed;
    logic enabled;
  } in_item_t;

  typedef struct packed {
    logic [1:0] click_event;
    logic [1:0] press_class;
  } out_item_t;

  typedef struct packed {
    logic [TickW-1:0] long_press_ticks;
    logic [TickW-1:0] double_window_ticks;
  } cfg_t;

endpackage

// ===== rtl/core/bcc_cfg.sv =====
`timescale 1ns / 1ps

module bcc_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bcc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [bcc_pkg::TickW-1:0]     cfg_data_i,
  output bcc_pkg::cfg_t                 cfg_o
);

  bcc_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        bcc_pkg::CfgLongPress: cfg_d.long_press_ticks    = cfg_data_i;
        bcc_pkg::CfgDoubleWin: cfg_d.double_window_ticks = cfg_data_i;
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.long_press_ticks    <= bcc_pkg::LongPressReset;
      cfg_q.double_window_ticks <= bcc_pkg::DoubleWinReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/core/bcc_fsm.sv =====
`timescale 1ns / 1ps

module bcc_fsm (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_en_i,
  input  bcc_pkg::in_item_t  item_i,
  input  bcc_pkg::cfg_t      cfg_i,
  output bcc_pkg::out_item_t result_o
);

  localparam int unsigned TickW = bcc_pkg::TickW;
  localparam int unsigned HoldW = bcc_pkg::HoldW;

  bcc_pkg::gesture_step_e step_q, step_d;
  bcc_pkg::press_class_e  class_q, class_d;
  logic [HoldW-1:0]       hold_q, hold_d;
  logic [TickW-1:0]       window_q, window_d;
  bcc_pkg::click_event_e  event_d;

  logic [HoldW-1:0] hold_inc;
  logic [HoldW-1:0] long_ext;
  logic             down;

  assign down     = item_i.key_pressed;
  assign hold_inc = hold_q + HoldW'(1);
  assign long_ext = {1'b0, cfg_i.long_press_ticks};

  always_comb begin
    step_d   = step_q;
    class_d  = class_q;
    hold_d   = hold_q;
    window_d = window_q;
    event_d  = bcc_pkg::EvNone;
    if (item_i.enabled) begin
      case (step_q)
        bcc_pkg::StIdle: begin
          if (down) begin
            class_d = bcc_pkg::ClsDown;
            step_d  = (window_q != '0) ? bcc_pkg::StSecond : bcc_pkg::StSettle;
          end else if (window_q != '0) begin
            window_d = window_q - TickW'(1);
            // The window ran out after a short press: report it now.
            if (window_q == TickW'(1) && class_q == bcc_pkg::ClsShort) begin
              event_d = bcc_pkg::EvShort;
              class_d = bcc_pkg::ClsUp;
            end
          end
        end
        bcc_pkg::StHold: begin
          if (down) begin
            if (hold_inc < long_ext) begin
              hold_d  = hold_inc;
              class_d = bcc_pkg::ClsShort;
            end else if (class_q != bcc_pkg::ClsLong) begin
              hold_d  = hold_inc;
              class_d = bcc_pkg::ClsLong;
              event_d = bcc_pkg::EvLong;
            end else begin
              hold_d = long_ext;
            end
          end else begin
            step_d = bcc_pkg::StSettle;
          end
        end
        bcc_pkg::StSettle: begin
          step_d = down ? bcc_pkg::StHold : bcc_pkg::StRelease;
        end
        bcc_pkg::StRelease: begin
          if (!down) begin
            if (hold_q < long_ext) begin
              window_d = cfg_i.double_window_ticks;
            end
            hold_d = '0;
            step_d = bcc_pkg::StIdle;
          end else begin
            step_d = bcc_pkg::StSettle;
          end
        end
        bcc_pkg::StSecond: begin
          if (!down) begin
            class_d = bcc_pkg::ClsUp;
            event_d = bcc_pkg::EvDouble;
            step_d  = bcc_pkg::StIdle;
          end
        end
        default: step_d = bcc_pkg::StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q   <= bcc_pkg::StIdle;
      class_q  <= bcc_pkg::ClsDown;
      hold_q   <= '0;
      window_q <= '0;
    end else if (step_en_i) begin
      step_q   <= step_d;
      class_q  <= class_d;
      hold_q   <= hold_d;
      window_q <= window_d;
    end
  end

  assign result_o.click_event = event_d;
  assign result_o.press_class = class_d;

endmodule

// ===== rtl/core/button_click_classifier_core.sv =====
`timescale 1ns / 1ps

// Button click classifier: one input item is one sampling tick of a push button
// (pressed level and an enable bit); one result item comes back for each input
// item, carrying the click event of that tick and the press class after it.
// Input channel: in_valid_i / in_stall_o / in_item_i. An item is taken at an
// edge where in_valid_i is high and in_stall_o is low.
// Output channel: out_valid_o / out_stall_i / out_item_o, same rule.
// Configuration: cfg_valid_i / cfg_ready_o with a register index and data;
// index 0 is the long press threshold, index 1 the double-click window.
// Other indexes are ignored. cfg_ready_o is always high.
// Each item is held in the input register; the classifier state machine then
// updates and the result register loads. Throughput is one item per cycle
// while the receiver does not stall.
// When the receiver stalls, the result holds in the output register and the
// input register still holds one more item; only then does in_stall_o rise.
// Reset clears both pipeline stages, the gesture state and loads the default
// thresholds (200 and 10 ticks).
module button_click_classifier_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  bcc_pkg::in_item_t           in_item_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output bcc_pkg::out_item_t          out_item_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [bcc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [bcc_pkg::TickW-1:0]   cfg_data_i
);

  bcc_pkg::cfg_t      cfg;
  bcc_pkg::in_item_t  in_item_q;
  bcc_pkg::out_item_t result;
  bcc_pkg::out_item_t out_item_q;
  logic               in_valid_q;
  logic               out_valid_q;
  logic               advance;
  logic               step_en;

  // The output register can take a new result when it is empty or being read.
  assign advance    = !out_valid_q || !out_stall_i;
  assign step_en    = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;

  bcc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  bcc_fsm u_fsm (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_en_i (step_en),
    .item_i    (in_item_q),
    .cfg_i     (cfg),
    .result_o  (result)
  );

  // Input register stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_item_q <= in_item_i;
    end
  end

  // Result register stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_en) begin
      out_item_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// ===== rtl/core/bcc_checker.sv =====
`timescale 1ns / 1ps

module bcc_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input bcc_pkg::out_item_t out_item_o
);

  // A held result must not change or vanish.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

  // Input back-pressure only arises behind a waiting result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a stalled result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.click_event == bcc_pkg::EvShort ||
                    out_item_o.click_event == bcc_pkg::EvDouble)
    |-> out_item_o.press_class == bcc_pkg::ClsUp)
    else $error("click event without release class");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.click_event == bcc_pkg::EvLong
    |-> out_item_o.press_class == bcc_pkg::ClsLong)
    else $error("long press event without long class");

endmodule

bind button_click_classifier_core bcc_checker u_bcc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);

// ===== tb/sv/bcc_click_checker.sv =====
`timescale 1ns / 1ps

// Watches the three channels of the click classifier and predicts each result.
// Results must come back in the order their ticks were taken.
module bcc_click_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  bcc_pkg::in_item_t           in_item_i,
  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  bcc_pkg::out_item_t          out_item_i,
  input  logic                        cfg_valid_i,
  input  logic                        cfg_ready_i,
  input  logic [bcc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [bcc_pkg::TickW-1:0]   cfg_data_i,
  output int                          mismatch_count_o,
  output int                          pending_o,
  output int                          checked_o,
  output int                          shorts_o,
  output int                          longs_o,
  output int                          doubles_o
);
  import bcc_pkg::*;

  // Predicted classifier state and thresholds.
  logic [TickW-1:0] long_ticks;
  logic [TickW-1:0] window_ticks;
  gesture_step_e    step;
  logic [HoldW-1:0] hold_ticks;
  logic [TickW-1:0] window_left;
  press_class_e     class_now;

  out_item_t expected_clicks[$];
  out_item_t want;

  function automatic out_item_t classify_tick(in_item_t tick);
    click_event_e ev;
    out_item_t    res;
    ev = EvNone;
    if (tick.enabled) begin
      case (step)
        StIdle: begin
          if (tick.key_pressed) begin
            class_now = ClsDown;
            step = (window_left != 0) ? StSecond : StSettle;
          end else if (window_left != 0) begin
            window_left = window_left - 1'b1;
            if (window_left == 0 && class_now == ClsShort) begin
              ev = EvShort;
              class_now = ClsUp;
            end
          end
        end
        StHold: begin
          if (tick.key_pressed) begin
            hold_ticks = hold_ticks + 1'b1;
            if (hold_ticks < long_ticks) begin
              class_now = ClsShort;
            end else if (class_now != ClsLong) begin
              class_now = ClsLong;
              ev = EvLong;
            end else begin
              hold_ticks = long_ticks;
            end
          end else begin
            step = StSettle;
          end
        end
        StSettle: begin
          step = tick.key_pressed ? StHold : StRelease;
        end
        StRelease: begin
          if (!tick.key_pressed) begin
            // Only a press that stayed short opens the double-click window.
            if (hold_ticks < long_ticks) window_left = window_ticks;
            hold_ticks = '0;
            step = StIdle;
          end else begin
            step = StSettle;
          end
        end
        StSecond: begin
          if (!tick.key_pressed) begin
            class_now = ClsUp;
            ev = EvDouble;
            step = StIdle;
          end
        end
        default: begin
          step = StIdle;
        end
      endcase
    end
    res.click_event = ev;
    res.press_class = class_now;
    return res;
  endfunction

  task automatic report(input string what, input out_item_t exp_item, input out_item_t got);
    if (mismatch_count_o < 10) begin
      $display("[%0t] %s: expected event %0d class %0d, got event %0d class %0d",
               $time, what, exp_item.click_event, exp_item.press_class,
               got.click_event, got.press_class);
    end
    mismatch_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_ticks = LongPressReset;
      window_ticks = DoubleWinReset;
      step = StIdle;
      hold_ticks = '0;
      window_left = '0;
      class_now = ClsDown;
      expected_clicks.delete();
      mismatch_count_o = 0;
      checked_o = 0;
      shorts_o = 0;
      longs_o = 0;
      doubles_o = 0;
      pending_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CfgLongPress) long_ticks = cfg_data_i;
        else if (cfg_index_i == CfgDoubleWin) window_ticks = cfg_data_i;
      end
      // Results are matched before new ticks are queued, so a result can never
      // pair with a tick taken at the same edge.
      if (out_valid_i && !out_stall_i) begin
        if (expected_clicks.size() == 0) begin
          report("result with nothing expected", '0, out_item_i);
        end else begin
          want = expected_clicks.pop_front();
          checked_o++;
          if (out_item_i.click_event !== want.click_event) begin
            report("click_event differs", want, out_item_i);
          end else if (out_item_i.press_class !== want.press_class) begin
            report("press_class differs", want, out_item_i);
          end
          case (want.click_event)
            EvShort:  shorts_o++;
            EvLong:   longs_o++;
            EvDouble: doubles_o++;
            default:  ;
          endcase
        end
      end
      if (in_valid_i && !in_stall_i) expected_clicks.push_back(classify_tick(in_item_i));
      pending_o = expected_clicks.size();
    end
  end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

// Stimulus and verdict for the button click classifier. The checker beside the
// block predicts every result; this module only makes ticks, stalls and
// threshold writes, and decides the outcome from the checker's counts.
module testbench;
  import bcc_pkg::*;

  // The two index codes that the block decodes to nothing.
  localparam logic [CfgIdxW-1:0] CfgSpareLo = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgSpareHi = 2'd3;

  localparam int CycleLimit = 400000;
  localparam int PhaseTicks = 64;
  localparam int NumFixed   = 8;

  // Fixed threshold and window settings for the random phases: zero window,
  // zero threshold, smallest and largest values, the reset pair, mixed pairs.
  localparam logic [TickW-1:0] PhaseLong [NumFixed] = '{8'd0, 8'd5, 8'd1, 8'd255,
                                                        8'd200, 8'd4, 8'd255, 8'd1};
  localparam logic [TickW-1:0] PhaseWin  [NumFixed] = '{8'd0, 8'd0, 8'd1, 8'd255,
                                                        8'd10, 8'd6, 8'd1, 8'd255};

  logic clk = 1'b0;
  logic rst_n;

  logic               in_valid;
  logic               in_stall;
  in_item_t           in_item;
  logic               out_valid;
  logic               out_stall;
  out_item_t          out_item;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index;
  logic [TickW-1:0]   cfg_data;

  int mismatches;
  int click_pending;
  int results_checked;
  int shorts_seen;
  int longs_seen;
  int doubles_seen;

  // Tick and phase bookkeeping used to shape the gestures.
  int               ticks_sent = 0;
  int               settings_used = 0;
  int               cycle_count = 0;
  int               in_calm = 0;
  int               out_calm = 0;
  logic [TickW-1:0] cur_long = LongPressReset;
  logic [TickW-1:0] cur_win = DoubleWinReset;

  always #4 clk = ~clk;

  button_click_classifier_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  bcc_click_checker click_check (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .in_item_i        (in_item),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .out_item_i       (out_item),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .mismatch_count_o (mismatches),
    .pending_o        (click_pending),
    .checked_o        (results_checked),
    .shorts_o         (shorts_seen),
    .longs_o          (longs_seen),
    .doubles_o        (doubles_seen)
  );

  // Draws how many cycles one side waits before its next item. Now and then a
  // calm stretch starts in which that side never waits, so back-to-back
  // traffic is exercised as well as gaps on every pipeline phase.
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 17);
  endfunction

  // Most ticks run with the classifier on; a few freeze it mid-gesture.
  function automatic logic rand_enable();
    return $urandom_range(0, 19) != 0;
  endfunction

  // Offers one tick and returns once it has been taken. Valid stays high from
  // one item to the next when no gap is drawn, so it is never dropped and
  // raised in the same time step.
  task automatic send_tick(input logic key, input logic en);
    int gap;
    gap = draw_wait(in_calm);
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_item.key_pressed <= key;
    in_item.enabled <= en;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    ticks_sent++;
  endtask

  // Stops offering ticks and waits until every result has come back, so the
  // block is idle before a threshold is rewritten.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (click_pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [TickW-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    if (idx == CfgLongPress) cur_long = value;
    else if (idx == CfgDoubleWin) cur_win = value;
  endtask

  task automatic set_thresholds(input logic [TickW-1:0] long_val,
                                input logic [TickW-1:0] win_val);
    drain();
    write_reg(CfgLongPress, long_val);
    write_reg(CfgDoubleWin, win_val);
    settings_used++;
  endtask

  // Random gestures: mostly a press of random length followed by a release of
  // random length, sized against the current threshold and window so that
  // short, long and double clicks all occur. The rest is loose noise on both
  // input bits. Very long holds and waits only happen now and then, so large
  // settings do not stretch the run.
  task automatic run_gestures(input int n_ticks);
    int stop_at;
    int downs;
    int ups;
    int lim;
    int k;
    stop_at = ticks_sent + n_ticks;
    while (ticks_sent < stop_at) begin
      if ($urandom_range(0, 9) < 8) begin
        lim = cur_long + 4;
        if (lim > 24 && $urandom_range(0, 11) != 0) lim = 24;
        downs = $urandom_range(1, lim);
        for (k = 0; k < downs; k++) send_tick(1'b1, rand_enable());
        lim = cur_win + 4;
        if (lim > 20 && $urandom_range(0, 11) != 0) lim = 20;
        ups = $urandom_range(1, lim);
        for (k = 0; k < ups; k++) send_tick(1'b0, rand_enable());
      end else begin
        k = $urandom_range(1, 8);
        repeat (k) send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  // The result side stalls for a freshly drawn number of cycles before each
  // item and then takes it.
  initial begin : result_side
    int hold;
    out_stall = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      hold = draw_wait(out_calm);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // Guards against a hang anywhere in the run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Run stopped at the cycle limit with %0d results outstanding.",
               click_pending);
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    int p;
    in_valid = 1'b0;
    in_item = '0;
    cfg_valid = 1'b0;
    cfg_index = CfgLongPress;
    cfg_data = '0;
    rst_n = 1'b0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part with a threshold of three ticks and a window of two.
    set_thresholds(8'd3, 8'd2);

    // Ticks while disabled change nothing.
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);

    // Short press, release, and the window running out: a short click.
    repeat (3) send_tick(1'b1, 1'b1);
    repeat (5) send_tick(1'b0, 1'b1);

    // Short press, release, second press inside the window: a double click on
    // the second release. The window keeps counting afterwards and its expiry
    // reports nothing.
    repeat (3) send_tick(1'b1, 1'b1);
    repeat (3) send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b1);
    repeat (2) send_tick(1'b0, 1'b1);

    // Held until the count reaches the threshold: one long press.
    repeat (5) send_tick(1'b1, 1'b1);
    repeat (3) send_tick(1'b0, 1'b1);

    // Threshold changed while the button is held. Raising it makes the hold
    // short again until the count catches up, which flags a second long
    // press; lowering it clamps the count to the new value.
    repeat (5) send_tick(1'b1, 1'b1);
    drain();
    write_reg(CfgLongPress, 8'd8);
    repeat (6) send_tick(1'b1, 1'b1);
    drain();
    write_reg(CfgLongPress, 8'd2);
    repeat (2) send_tick(1'b1, 1'b1);
    repeat (3) send_tick(1'b0, 1'b1);

    // Writes to the undecoded indexes must leave both thresholds alone.
    drain();
    write_reg(CfgSpareLo, TickW'($urandom_range(0, 255)));
    write_reg(CfgSpareHi, TickW'($urandom_range(0, 255)));
    run_gestures(20);

    // Random phases over fixed extremes and two random small settings.
    for (p = 0; p < NumFixed + 2; p++) begin
      if (p < NumFixed) begin
        set_thresholds(PhaseLong[p], PhaseWin[p]);
      end else begin
        set_thresholds(TickW'($urandom_range(1, 16)), TickW'($urandom_range(1, 16)));
      end
      run_gestures(PhaseTicks);
    end

    drain();
    repeat (8) @(negedge clk);

    $display("Sent %0d ticks under %0d threshold settings; %0d results checked.",
             ticks_sent, settings_used, results_checked);
    $display("Predicted events: %0d short clicks, %0d long presses, %0d double clicks.",
             shorts_seen, longs_seen, doubles_seen);
    if (mismatches == 0 && click_pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/bcc_pkg.sv
rtl/core/bcc_cfg.sv
rtl/core/bcc_fsm.sv
rtl/core/button_click_classifier_core.sv
rtl/core/bcc_checker.sv
tb/sv/bcc_click_checker.sv
tb/sv/testbench.sv
